[sv/sgmc_pkg.sv]
// package for the sliding gate motor controller core
// holds register indexes, reset constants, radio command codes and the sample type
// no dependencies
package sgmc_pkg;

    localparam int unsigned TIMER_WIDTH_DEFAULT = 16;
    localparam int unsigned CFG_WIDTH           = 16;
    localparam int unsigned APB_DATA_WIDTH      = 32;
    localparam int unsigned APB_ADDR_WIDTH      = 3;

    localparam logic [CFG_WIDTH-1:0] LOCKOUT_RESET = 16'd5000;
    localparam logic [CFG_WIDTH-1:0] START_RESET   = 16'd2000;

    typedef enum logic {
        REG_LOCKOUT = 1'b0,
        REG_START   = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        RADIO_NONE  = 2'd0,
        RADIO_OPEN  = 2'd1,
        RADIO_CLOSE = 2'd2,
        RADIO_STOP  = 2'd3
    } radio_cmd_t;

    typedef struct packed {
        logic       emergency_stop;
        logic       closed_limit;
        logic       opened_limit;
        logic       pause_button;
        logic       change_button;
        logic       photocell_blocked;
        radio_cmd_t radio_command;
        logic       ms_tick;
    } sample_t;

endpackage

[sv/sgmc_channels.sv]
// valid/ready channel interfaces for samples in and gate status out
// depends on sgmc_pkg
interface sgmc_sample_if;
    logic                  valid;
    logic                  ready;
    logic                  emergency_stop;
    logic                  closed_limit;
    logic                  opened_limit;
    logic                  pause_button;
    logic                  change_button;
    logic                  photocell_blocked;
    sgmc_pkg::radio_cmd_t  radio_command;
    logic                  ms_tick;

    modport source (
        output valid, emergency_stop, closed_limit, opened_limit, pause_button,
               change_button, photocell_blocked, radio_command, ms_tick,
        input  ready
    );
    modport sink (
        input  valid, emergency_stop, closed_limit, opened_limit, pause_button,
               change_button, photocell_blocked, radio_command, ms_tick,
        output ready
    );
endinterface

interface sgmc_result_if;
    logic valid;
    logic ready;
    logic motor_on;
    logic direction_drive;
    logic paused_flag;
    logic obstruction_flag;

    modport source (
        output valid, motor_on, direction_drive, paused_flag, obstruction_flag,
        input  ready
    );
    modport sink (
        input  valid, motor_on, direction_drive, paused_flag, obstruction_flag,
        output ready
    );
endinterface

[sv/sliding_gate_motor_controller_core.sv]
// sliding gate motor controller: one control-loop sample per request, one status result each
// a request accepted at the sample port passes through the sample register, then the state
// registers, which also serve as the result register
// throughput: one request per cycle, stalled only while a result waits and the sample stage is full
// reset: motor off, closing, not paused, no obstruction, lockout 5000 ms (capped to the timer width),
// start delay cleared, registers back to 5000 and 2000 ms; depends on sgmc_pkg and sgmc_channels
module sliding_gate_motor_controller_core #(
    parameter int unsigned TIMER_WIDTH = sgmc_pkg::TIMER_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    sgmc_sample_if.sink                           sample,
    sgmc_result_if.source                         result,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sgmc_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [sgmc_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [sgmc_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                  pready
);

    localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);
    localparam logic [31:0] LOCKOUT_RESET_WIDE = {16'b0, sgmc_pkg::LOCKOUT_RESET};
    localparam logic [31:0] LOCKOUT_RESET_SAT =
        (LOCKOUT_RESET_WIDE > TIMER_MAX) ? TIMER_MAX : LOCKOUT_RESET_WIDE;

    // configuration registers
    logic [sgmc_pkg::CFG_WIDTH-1:0] lockout_cfg_reg;
    logic [sgmc_pkg::CFG_WIDTH-1:0] start_cfg_reg;
    logic                           cfg_write;
    sgmc_pkg::reg_index_t           cfg_index;

    // sample stage
    logic              s1_valid_reg;
    sgmc_pkg::sample_t s1_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              advance;

    // controller state
    logic                   paused_reg, paused_next;
    logic                   running_reg, running_next;
    logic                   travel_dir_reg, travel_dir_next;
    logic                   dir_relay_reg, dir_relay_next;
    logic                   obstruction_reg, obstruction_next;
    logic                   pause_prev_reg, pause_prev_next;
    logic                   change_prev_reg, change_prev_next;
    logic [TIMER_WIDTH-1:0] lockout_rem_reg, lockout_rem_next;
    logic [TIMER_WIDTH-1:0] start_rem_reg, start_rem_next;

    logic [31:0]            lockout_wide;
    logic [31:0]            start_wide;
    logic [TIMER_WIDTH-1:0] lockout_load;
    logic [TIMER_WIDTH-1:0] start_load;

    function automatic logic run_blocked(input logic dir, input logic at_closed,
                                         input logic at_opened);
        return (dir && at_opened) || (!dir && at_closed);
    endfunction

    // apb port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = sgmc_pkg::reg_index_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_index)
            sgmc_pkg::REG_LOCKOUT: prdata = {16'b0, lockout_cfg_reg};
            sgmc_pkg::REG_START:   prdata = {16'b0, start_cfg_reg};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_cfg_reg <= sgmc_pkg::LOCKOUT_RESET;
            start_cfg_reg   <= sgmc_pkg::START_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sgmc_pkg::REG_LOCKOUT: lockout_cfg_reg <= pwdata[15:0];
                sgmc_pkg::REG_START:   start_cfg_reg   <= pwdata[15:0];
                default:               ;
            endcase
        end
    end

    // saturating counter loads
    assign lockout_wide = {16'b0, lockout_cfg_reg};
    assign start_wide   = {16'b0, start_cfg_reg};
    assign lockout_load = (lockout_wide > TIMER_MAX) ? TIMER_MAX[TIMER_WIDTH-1:0]
                                                     : lockout_wide[TIMER_WIDTH-1:0];
    assign start_load   = (start_wide > TIMER_MAX) ? TIMER_MAX[TIMER_WIDTH-1:0]
                                                   : start_wide[TIMER_WIDTH-1:0];

    // handshake and stage control
    assign out_free     = !out_valid_reg || result.ready;
    assign advance      = s1_valid_reg && out_free;
    assign sample.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
                s1_valid_reg <= sample.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_reg.emergency_stop    <= sample.emergency_stop;
            s1_reg.closed_limit      <= sample.closed_limit;
            s1_reg.opened_limit      <= sample.opened_limit;
            s1_reg.pause_button      <= sample.pause_button;
            s1_reg.change_button     <= sample.change_button;
            s1_reg.photocell_blocked <= sample.photocell_blocked;
            s1_reg.radio_command     <= sample.radio_command;
            s1_reg.ms_tick           <= sample.ms_tick;
        end
    end

    // control step for the sample held in stage one
    always_comb
    begin
        paused_next      = paused_reg;
        running_next     = running_reg;
        travel_dir_next  = travel_dir_reg;
        dir_relay_next   = dir_relay_reg;
        obstruction_next = obstruction_reg;
        pause_prev_next  = pause_prev_reg;
        change_prev_next = change_prev_reg;
        lockout_rem_next = lockout_rem_reg;
        start_rem_next   = start_rem_reg;

        if (s1_reg.ms_tick)
        begin
            if (lockout_rem_next != '0)
                lockout_rem_next = lockout_rem_next - TIMER_WIDTH'(1);
            if (start_rem_next != '0)
                start_rem_next = start_rem_next - TIMER_WIDTH'(1);
        end

        // radio command
        unique case (s1_reg.radio_command)
            sgmc_pkg::RADIO_OPEN:
            begin
                if (!travel_dir_next || !running_next)
                begin
                    running_next    = 1'b0;
                    travel_dir_next = 1'b1;
                    if (!run_blocked(1'b1, s1_reg.closed_limit, s1_reg.opened_limit))
                    begin
                        dir_relay_next = 1'b1;
                        running_next   = 1'b1;
                    end
                end
            end
            sgmc_pkg::RADIO_CLOSE:
            begin
                if (travel_dir_next || !running_next)
                begin
                    running_next    = 1'b0;
                    travel_dir_next = 1'b0;
                    if (!run_blocked(1'b0, s1_reg.closed_limit, s1_reg.opened_limit))
                    begin
                        dir_relay_next = 1'b0;
                        running_next   = 1'b1;
                    end
                end
            end
            sgmc_pkg::RADIO_STOP:
            begin
                if (!pause_prev_next)
                begin
                    paused_next = !paused_next;
                    if (paused_next)
                        running_next = 1'b0;
                    else if (!running_next &&
                             !run_blocked(travel_dir_next, s1_reg.closed_limit,
                                          s1_reg.opened_limit))
                    begin
                        dir_relay_next = travel_dir_next;
                        running_next   = 1'b1;
                    end
                end
                pause_prev_next = 1'b1;
            end
            sgmc_pkg::RADIO_NONE: ;
            default: ;
        endcase

        if (s1_reg.emergency_stop)
        begin
            running_next = 1'b0;
        end
        else if (s1_reg.photocell_blocked && !s1_reg.closed_limit)
        begin
            // obstruction: reverse to opening
            running_next     = 1'b0;
            obstruction_next = 1'b1;
            travel_dir_next  = 1'b1;
            if (!run_blocked(1'b1, s1_reg.closed_limit, s1_reg.opened_limit))
            begin
                dir_relay_next = 1'b1;
                running_next   = 1'b1;
            end
        end
        else
        begin
            // pause press edge
            if (s1_reg.pause_button && !pause_prev_next)
            begin
                paused_next = !paused_next;
                if (paused_next)
                    running_next = 1'b0;
                else if (!running_next &&
                         !run_blocked(travel_dir_next, s1_reg.closed_limit,
                                      s1_reg.opened_limit))
                begin
                    dir_relay_next = travel_dir_next;
                    running_next   = 1'b1;
                end
            end
            pause_prev_next = s1_reg.pause_button;

            // direction change with lockout
            if (s1_reg.change_button && !change_prev_next && !paused_next &&
                lockout_rem_next == '0)
            begin
                running_next     = 1'b0;
                travel_dir_next  = !travel_dir_next;
                lockout_rem_next = lockout_load;
                start_rem_next   = start_load;
            end
            change_prev_next = s1_reg.change_button;

            // limit stop
            if (running_next && run_blocked(travel_dir_next, s1_reg.closed_limit,
                                            s1_reg.opened_limit))
                running_next = 1'b0;

            // delayed auto-resume
            if (!running_next && !paused_next && start_rem_next == '0 &&
                !run_blocked(travel_dir_next, s1_reg.closed_limit, s1_reg.opened_limit))
            begin
                dir_relay_next = travel_dir_next;
                running_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paused_reg      <= 1'b0;
            running_reg     <= 1'b0;
            travel_dir_reg  <= 1'b0;
            dir_relay_reg   <= 1'b0;
            obstruction_reg <= 1'b0;
            pause_prev_reg  <= 1'b0;
            change_prev_reg <= 1'b0;
            lockout_rem_reg <= LOCKOUT_RESET_SAT[TIMER_WIDTH-1:0];
            start_rem_reg   <= '0;
        end
        else if (advance)
        begin
            paused_reg      <= paused_next;
            running_reg     <= running_next;
            travel_dir_reg  <= travel_dir_next;
            dir_relay_reg   <= dir_relay_next;
            obstruction_reg <= obstruction_next;
            pause_prev_reg  <= pause_prev_next;
            change_prev_reg <= change_prev_next;
            lockout_rem_reg <= lockout_rem_next;
            start_rem_reg   <= start_rem_next;
        end
    end

    // status only moves when a new result is loaded, so it holds while stalled
    assign result.valid            = out_valid_reg;
    assign result.motor_on         = running_reg;
    assign result.direction_drive  = dir_relay_reg;
    assign result.paused_flag      = paused_reg;
    assign result.obstruction_flag = obstruction_reg;

endmodule
